@@ hdl/prrq_pkg.sv @@
// purge range ring queue: shared types and constants
// payload words, ring entry, controller state and command/status structs
// no dependencies
`default_nettype none

package prrq_pkg;

	// fixed field widths
	localparam int BASE_W     = 48;
	localparam int ADDR_W     = 49;
	localparam int END_W      = 50;
	localparam int LEN_W      = 28;
	localparam int IDX_W      = 16;
	localparam int CNT_W      = 16;
	localparam int CALLS_W    = 6;
	localparam int PAGES_W    = 22;
	localparam int PAGES_ACC_W = PAGES_W + 1;
	localparam int TOTAL_W    = 32;
	localparam int TCNT_W     = 6;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 50;

	localparam logic [TCNT_W-1:0] TCNT_MAX = '1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_BUDGET_CALLS = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BUDGET_PAGES = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ARENA_BASE   = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ARENA_LIMIT  = 4'd3;

	typedef enum logic [0:0] {
		OP_PUSH = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		KIND_PUSH_OK   = 2'd0,
		KIND_PUSH_DROP = 2'd1,
		KIND_PURGE     = 2'd2,
		KIND_TICK_DONE = 2'd3
	} kind_t;

	typedef struct packed {
		op_t               op;
		logic [BASE_W-1:0] segment_base;
		logic [IDX_W-1:0]  page_index;
		logic [CNT_W-1:0]  page_count;
	} item_t;

	typedef struct packed {
		kind_t              kind;
		logic [ADDR_W-1:0]  purge_address;
		logic [LEN_W-1:0]   purge_length;
		logic               last;
		logic [TOTAL_W-1:0] drop_total;
		logic [TOTAL_W-1:0] push_total;
		logic [TCNT_W-1:0]  skipped_in_tick;
		logic [TCNT_W-1:0]  discarded_in_tick;
	} result_t;

	typedef struct packed {
		logic [BASE_W-1:0] base;
		logic [IDX_W-1:0]  idx;
		logic [CNT_W-1:0]  cnt;
	} ring_entry_t;

	typedef enum logic [0:0] {
		ST_IDLE  = 1'b0,
		ST_DRAIN = 1'b1
	} ctl_state_t;

	// controller to datapath
	typedef struct packed {
		logic push;
		logic tick_start;
		logic issue;
		logic advance;
		logic summary;
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic slot_ok;
		logic ring_empty;
		logic busy_s1;
		logic busy_s2;
	} ctl_status_t;

endpackage

`default_nettype wire

@@ hdl/prrq_ctrl.sv @@
// purge range ring queue: controller state machine
// sequences pushes and tick drains, drives the input stall
// depends on prrq_pkg
`default_nettype none

module prrq_ctrl import prrq_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	input  wire op_t         item_op,
	output logic             item_stall,
	input  wire ctl_status_t status,
	output ctl_cmd_t         cmd
);

	ctl_state_t state_q;
	ctl_state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		item_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				item_stall = !status.slot_ok;
				if (item_valid && status.slot_ok) begin
					if (item_op == OP_PUSH) begin
						cmd.push = 1'b1;
					end else begin
						cmd.tick_start = 1'b1;
						state_d        = ST_DRAIN;
					end
				end
			end
			ST_DRAIN: begin
				// whole drain pipe moves only when the result slot can take a word
				cmd.advance = status.slot_ok;
				cmd.issue   = status.slot_ok && !status.ring_empty;
				if (status.slot_ok && status.ring_empty && !status.busy_s1 &&
				    !status.busy_s2) begin
					cmd.summary = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ hdl/prrq_dpath.sv @@
// purge range ring queue: datapath
// ring memory, pointers, drain pipeline, budget counters, result register
// depends on prrq_pkg
`default_nettype none

module prrq_dpath import prrq_pkg::*; #(
	parameter int RING_DEPTH = 32,
	parameter int PAGE_SHIFT = 12
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire ctl_cmd_t              cmd,
	output ctl_status_t                status,
	input  wire item_t                 item,
	input  wire logic [CALLS_W-1:0]    budget_calls,
	input  wire logic [PAGES_W-1:0]    budget_pages,
	input  wire logic [BASE_W-1:0]     arena_base,
	input  wire logic [END_W-1:0]      arena_limit,
	output logic                       result_valid,
	input  wire logic                  result_stall,
	output result_t                    result
);

	localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(RING_DEPTH - 1);

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		next_ptr = (p == LAST_SLOT) ? '0 : p + 1'b1;
	endfunction

	logic [PTR_W-1:0]       wr_ptr_q;
	logic [PTR_W-1:0]       rd_ptr_q;
	logic                   full;
	ring_entry_t            ring_mem [RING_DEPTH];
	ring_entry_t            entry_s1;
	logic                   v_s1;
	logic                   v_s2;
	logic [ADDR_W-1:0]      addr_s2;
	logic [END_W-1:0]       end_s2;
	logic [LEN_W-1:0]       len_s2;
	logic [CNT_W-1:0]       cnt_s2;
	logic [IDX_W:0]         span_sum;
	logic [CALLS_W-1:0]     calls_q;
	logic [PAGES_ACC_W-1:0] pages_q;
	logic [TCNT_W-1:0]      skipped_q;
	logic [TCNT_W-1:0]      discarded_q;
	logic [TOTAL_W-1:0]     drop_q;
	logic [TOTAL_W-1:0]     push_q;
	logic                   budget_hit;
	logic                   outside;
	logic                   take_cmd;
	logic                   load;
	logic                   out_valid_q;
	result_t                out_q;
	result_t                out_d;

	assign full = (next_ptr(wr_ptr_q) == rd_ptr_q);

	// status to controller
	assign status.slot_ok    = !out_valid_q || !result_stall;
	assign status.ring_empty = (rd_ptr_q == wr_ptr_q);
	assign status.busy_s1    = v_s1;
	assign status.busy_s2    = v_s2;

	// ring memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.push && !full) begin
			ring_mem[wr_ptr_q] <= '{base: item.segment_base, idx: item.page_index,
				cnt: item.page_count};
		end
		if (cmd.issue) begin
			entry_s1 <= ring_mem[rd_ptr_q];
		end
	end

	// pointers and pipe valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
		end else begin
			if (cmd.push && !full) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (cmd.issue) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (cmd.advance) begin
				v_s1 <= cmd.issue;
				v_s2 <= v_s1;
			end
		end
	end

	// byte address, end address and length of the entry
	assign span_sum = {1'b0, entry_s1.idx} + {1'b0, entry_s1.cnt};

	always_ff @(posedge clk) begin
		if (cmd.advance && v_s1) begin
			addr_s2 <= ADDR_W'(entry_s1.base) + (ADDR_W'(entry_s1.idx) << PAGE_SHIFT);
			end_s2  <= END_W'(entry_s1.base) + (END_W'(span_sum) << PAGE_SHIFT);
			len_s2  <= LEN_W'(entry_s1.cnt) << PAGE_SHIFT;
			cnt_s2  <= entry_s1.cnt;
		end
	end

	// budget first, then arena window
	assign budget_hit = (calls_q >= budget_calls) ||
		(pages_q >= PAGES_ACC_W'(budget_pages));
	assign outside    = (addr_s2 < ADDR_W'(arena_base)) || (end_s2 > arena_limit);
	assign take_cmd   = cmd.advance && v_s2 && !budget_hit && !outside;

	// per-tick and running counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			calls_q     <= '0;
			pages_q     <= '0;
			skipped_q   <= '0;
			discarded_q <= '0;
			drop_q      <= '0;
			push_q      <= '0;
		end else begin
			if (cmd.tick_start) begin
				calls_q     <= '0;
				pages_q     <= '0;
				skipped_q   <= '0;
				discarded_q <= '0;
			end else if (cmd.advance && v_s2) begin
				if (budget_hit) begin
					if (discarded_q != TCNT_MAX) begin
						discarded_q <= discarded_q + 1'b1;
					end
				end else if (outside) begin
					if (skipped_q != TCNT_MAX) begin
						skipped_q <= skipped_q + 1'b1;
					end
				end else begin
					calls_q <= calls_q + 1'b1;
					pages_q <= pages_q + PAGES_ACC_W'(cnt_s2);
				end
			end
			if (cmd.push) begin
				if (full) begin
					drop_q <= drop_q + 1'b1;
				end else begin
					push_q <= push_q + 1'b1;
				end
			end
		end
	end

	// next result word
	always_comb begin
		out_d                   = '0;
		out_d.last              = 1'b1;
		out_d.drop_total        = drop_q;
		out_d.push_total        = push_q;
		if (cmd.push) begin
			if (full) begin
				out_d.kind       = KIND_PUSH_DROP;
				out_d.drop_total = drop_q + 1'b1;
			end else begin
				out_d.kind       = KIND_PUSH_OK;
				out_d.push_total = push_q + 1'b1;
			end
		end else if (take_cmd) begin
			out_d.kind          = KIND_PURGE;
			out_d.purge_address = addr_s2;
			out_d.purge_length  = len_s2;
			out_d.last          = 1'b0;
		end else begin
			out_d.kind              = KIND_TICK_DONE;
			out_d.skipped_in_tick   = skipped_q;
			out_d.discarded_in_tick = discarded_q;
		end
	end

	assign load = cmd.push || take_cmd || cmd.summary;

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= out_d;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

`default_nettype wire

@@ hdl/purge_range_ring_queue.sv @@
// Purge range ring queue, top level.
// Holds the configuration registers; joins controller and datapath.
//
// Input channel (item_valid, item_stall, item): a push word stores a page
// range in the ring, or drops it when RING_DEPTH-1 entries are pending. A
// tick word drains the ring oldest first, giving one purge word per entry
// that is in budget and inside the arena window, then a tick-done word.
// Output channel (result_valid, result_stall, result): one result register.
// Configuration (cfg_valid, cfg_ready, cfg_index, cfg_data): always ready;
// indexes 0..3 are budget_calls, budget_pages, arena_base, arena_limit, other
// indexes are ignored.
// Timing: a push word's result is registered and shows in the cycle after
// acceptance; pushes go at one per cycle while results are taken. A tick
// reads the single ring read port once per cycle while the result slot can
// take a word; it ends with the tick-done word, and no input word is
// taken until that word is loaded.
// While result_stall holds a word, the drain pipeline freezes and item_stall
// stays high. Reset empties the ring, clears totals and loads the register
// defaults; ring contents are left as they are.
`default_nettype none

module purge_range_ring_queue import prrq_pkg::*; #(
	parameter int RING_DEPTH = 32,
	parameter int PAGE_SHIFT = 12
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  item_valid,
	output logic                       item_stall,
	input  wire item_t                 item,
	output logic                       result_valid,
	input  wire logic                  result_stall,
	output result_t                    result,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	logic [CALLS_W-1:0] budget_calls_q;
	logic [PAGES_W-1:0] budget_pages_q;
	logic [BASE_W-1:0]  arena_base_q;
	logic [END_W-1:0]   arena_limit_q;
	ctl_cmd_t           cmd;
	ctl_status_t        status;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_calls_q <= CALLS_W'(8);
			budget_pages_q <= PAGES_W'(1024);
			arena_base_q   <= '0;
			arena_limit_q  <= {2'b01, {BASE_W{1'b0}}};
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_BUDGET_CALLS: budget_calls_q <= cfg_data[CALLS_W-1:0];
				CFG_BUDGET_PAGES: budget_pages_q <= cfg_data[PAGES_W-1:0];
				CFG_ARENA_BASE:   arena_base_q   <= cfg_data[BASE_W-1:0];
				CFG_ARENA_LIMIT:  arena_limit_q  <= cfg_data[END_W-1:0];
				default: begin
				end
			endcase
		end
	end

	prrq_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_op    (item.op),
		.item_stall (item_stall),
		.status     (status),
		.cmd        (cmd)
	);

	prrq_dpath #(
		.RING_DEPTH (RING_DEPTH),
		.PAGE_SHIFT (PAGE_SHIFT)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.item         (item),
		.budget_calls (budget_calls_q),
		.budget_pages (budget_pages_q),
		.arena_base   (arena_base_q),
		.arena_limit  (arena_limit_q),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

`default_nettype wire

@@ hdl/prrq_checker.sv @@
// purge range ring queue: port-level checker and its bind
// watches the input and output channels of the top level
// depends on prrq_pkg
`default_nettype none

module prrq_checker import prrq_pkg::*; (
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    item_valid,
	input wire logic    item_stall,
	input wire item_t   item,
	input wire logic    result_valid,
	input wire logic    result_stall,
	input wire result_t result
);

	// a held result word stays put
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result word changed while stalled");

	// a blocked result blocks the input side too
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |-> item_stall)
		else $error("input taken while result slot is blocked");

	// a push word answers in the next cycle with a single push result
	a_push_answer: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && item.op == OP_PUSH |=>
		result_valid && result.last &&
		(result.kind == KIND_PUSH_OK || result.kind == KIND_PUSH_DROP))
		else $error("push word without a push result");

	// a tick word holds off input right after it is taken
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && item.op == OP_TICK |=> item_stall)
		else $error("input taken right after a tick");

	// only purge words leave last low
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ((result.kind == KIND_PURGE) == !result.last))
		else $error("last flag does not match result kind");

endmodule

bind purge_range_ring_queue prrq_checker u_prrq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.item         (item),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

`default_nettype wire
